### sv/rgh_pkg.sv
package rgh_pkg;

  localparam int NUM_BINS  = 32;
  localparam int BIN_W     = 5;
  localparam int CH_W      = 5;
  localparam int PIX_W     = 16;
  localparam int HGT_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd3;

  localparam logic [HGT_W-1:0] HEIGHT_RST = 16'd256;

  localparam longint unsigned RGH_MAX_PIXELS = 64'd4194304;

  // Reciprocal constants for the divisions by 15 and by 3.
  localparam logic [11:0] RECIP15    = 12'd2185;
  localparam int          RECIP15_SH = 15;
  localparam logic [9:0]  RECIP3     = 10'd683;
  localparam int          RECIP3_SH  = 11;

  typedef struct packed {
    logic             vld;
    logic [BIN_W-1:0] gray;
    logic             last;
  } rgh_pix_t;

  typedef struct packed {
    logic             start;
    logic [BIN_W-1:0] idx;
    logic             last;
  } rgh_feed_t;

  typedef enum logic [1:0] {
    HS_COUNT,
    HS_READ,
    HS_FEED
  } rgh_hstate_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } rgh_sstate_t;

endpackage

### sv/rgh_pix_if.sv
interface rgh_pix_if import rgh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

### sv/rgh_bin_if.sv
interface rgh_bin_if import rgh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] bin_index;
  logic [HGT_W-1:0] bin_height;
  logic             last_bin;

  modport source (output valid, output bin_index, output bin_height, output last_bin,
                  input ready);
  modport sink (input valid, input bin_index, input bin_height, input last_bin,
                output ready);
endinterface

### sv/rgh_gray.sv
module rgh_gray import rgh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [PIX_W-1:0] pixel,
  input  logic             last_pixel,
  input  logic             adj_en,
  input  logic [8:0]       bright,
  input  logic [8:0]       contrast,
  output rgh_pix_t         pix
);

  logic signed [8:0]  b_s, c_s, b_adj, c_adj;
  logic signed [5:0]  b_q, c_q;
  logic signed [6:0]  c_m;
  logic signed [9:0]  b15;
  logic               adj;

  logic signed [12:0] v_nxt [3];
  logic signed [12:0] v_r   [3];
  logic               a_vld_r, a_last_r;

  logic [CH_W-1:0]    q [3];
  logic [6:0]         sum_nxt, sum_r;
  logic               b_vld_r, b_last_r;
  logic [16:0]        prod3;

  // Division by 8 truncating toward zero.
  always_comb begin
    b_s   = bright;
    c_s   = contrast;
    b_adj = b_s[8] ? b_s + 9'sd7 : b_s;
    c_adj = c_s[8] ? c_s + 9'sd7 : c_s;
    b_q   = 6'(b_adj >>> 3);
    c_q   = 6'(c_adj >>> 3);
    c_m   = 7'(c_q) + 7'sd15;
    b15   = 10'(b_q) * 10'sd15;
    adj   = adj_en && ((b_q != 6'sd0) || (c_q != 6'sd0));
  end

  // Without adjustment the channel goes through as 15*i, which maps back to i.
  function automatic logic signed [12:0] chan_v(input logic [CH_W-1:0] i,
                                                input logic signed [6:0] cm,
                                                input logic signed [9:0] bb,
                                                input logic en);
    logic signed [12:0] iv;
    iv = {8'b0, i};
    return en ? (iv * 13'(cm)) + 13'(bb) : iv * 13'sd15;
  endfunction

  function automatic logic [CH_W-1:0] chan_q(input logic signed [12:0] v);
    logic [20:0] prod;
    prod = 21'(v[8:0]) * 21'(RECIP15);
    if (v < 13'sd0) begin
      return '0;
    end else if (v >= 13'sd480) begin
      return '1;
    end else begin
      return prod[RECIP15_SH +: CH_W];
    end
  endfunction

  always_comb begin
    v_nxt[0] = chan_v(pixel[14:10], c_m, b15, adj);
    v_nxt[1] = chan_v(pixel[9:5], c_m, b15, adj);
    v_nxt[2] = chan_v(pixel[4:0], c_m, b15, adj);
    for (int k = 0; k < 3; k++) begin
      q[k] = chan_q(v_r[k]);
    end
    sum_nxt = 7'(q[0]) + 7'(q[1]) + 7'(q[2]);
    prod3   = 17'(sum_r) * 17'(RECIP3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= take;
      b_vld_r <= a_vld_r;
    end
    if (take) begin
      v_r      <= v_nxt;
      a_last_r <= last_pixel;
    end
    sum_r    <= sum_nxt;
    b_last_r <= a_last_r;
  end

  assign pix.vld  = b_vld_r;
  assign pix.gray = prod3[RECIP3_SH +: BIN_W];
  assign pix.last = b_last_r;

endmodule

### sv/rgh_hist.sv
module rgh_hist import rgh_pkg::*; #(
  parameter longint unsigned MAX_PIXELS = RGH_MAX_PIXELS,
  parameter int              CNT_W      = $clog2(MAX_PIXELS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rgh_pix_t         pix,
  input  logic             sc_idle,
  output rgh_feed_t        feed,
  output logic [CNT_W-1:0] count,
  output logic [CNT_W-1:0] max_count,
  output logic             counting
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

  logic [CNT_W-1:0]    mem [NUM_BINS];
  logic [NUM_BINS-1:0] ent_vld_r;

  rgh_hstate_t      st_r, st_nxt;
  logic [BIN_W-1:0] k_r, k_nxt;
  logic [BIN_W-1:0] raddr;
  logic [CNT_W-1:0] rd_r;
  logic             rvld_r;
  logic             clr;

  logic             w_vld_r, w_last_r;
  logic [BIN_W-1:0] w_addr_r;
  logic             fw_vld_r;
  logic [BIN_W-1:0] fw_addr_r;
  logic [CNT_W-1:0] fw_data_r;
  logic [CNT_W-1:0] base, newc;
  logic [CNT_W-1:0] max_r, max_nxt;

  // Back-to-back hits on one bin see the write of the cycle before.
  always_comb begin
    if (fw_vld_r && (fw_addr_r == w_addr_r)) begin
      base = fw_data_r;
    end else begin
      base = rvld_r ? rd_r : '0;
    end
    newc = (base < MAX_CNT) ? base + CNT_W'(1) : base;
  end

  always_comb begin
    st_nxt     = st_r;
    k_nxt      = k_r;
    max_nxt    = max_r;
    clr        = 1'b0;
    feed.start = 1'b0;
    feed.idx   = k_r;
    feed.last  = (k_r == BIN_W'(NUM_BINS - 1));
    raddr      = pix.gray;
    if (w_vld_r && (newc > max_r)) begin
      max_nxt = newc;
    end
    case (st_r)
      HS_COUNT: begin
        if (w_vld_r && w_last_r) begin
          st_nxt = HS_READ;
        end
      end
      HS_READ: begin
        raddr = k_r;
        if (sc_idle) begin
          clr    = 1'b1;
          st_nxt = HS_FEED;
        end
      end
      HS_FEED: begin
        feed.start = 1'b1;
        k_nxt      = k_r + BIN_W'(1);
        if (feed.last) begin
          max_nxt = '0;
          st_nxt  = HS_COUNT;
        end else begin
          st_nxt = HS_READ;
        end
      end
      default: st_nxt = HS_COUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= HS_COUNT;
      k_r       <= '0;
      max_r     <= '0;
      ent_vld_r <= '0;
      w_vld_r   <= 1'b0;
      fw_vld_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      k_r      <= k_nxt;
      max_r    <= max_nxt;
      w_vld_r  <= pix.vld;
      fw_vld_r <= w_vld_r;
      if (w_vld_r) begin
        ent_vld_r[w_addr_r] <= 1'b1;
      end
      if (clr) begin
        ent_vld_r[raddr] <= 1'b0;
      end
    end
    w_addr_r  <= pix.gray;
    w_last_r  <= pix.last;
    fw_addr_r <= w_addr_r;
    fw_data_r <= newc;
    rvld_r    <= ent_vld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (w_vld_r) begin
      mem[w_addr_r] <= newc;
    end
    rd_r <= mem[raddr];
  end

  assign count     = rvld_r ? rd_r : '0;
  assign max_count = max_r;
  assign counting  = (st_r == HS_COUNT);

endmodule

### sv/rgh_scale.sv
module rgh_scale import rgh_pkg::*; #(
  parameter int CNT_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rgh_feed_t        feed,
  input  logic [CNT_W-1:0] count,
  input  logic [CNT_W-1:0] max_count,
  input  logic [HGT_W-1:0] h1,
  output logic             idle,
  rgh_bin_if.source        out
);

  // Numerator 2*count*h1 + max stays below max * 2^(HGT_W+1).
  localparam int NW     = CNT_W + HGT_W + 1;
  localparam int STEP_W = $clog2(HGT_W);

  rgh_sstate_t       st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, mx_r;
  logic [NW-1:0]     n_r, n_nxt, d_r, d_nxt;
  logic [HGT_W-1:0]  q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BIN_W-1:0]  idx_r;
  logic              last_r, zero_r;
  logic [NW-1:0]     prod;
  logic              ge, load;

  logic              o_vld_r;
  logic [BIN_W-1:0]  o_idx_r;
  logic [HGT_W-1:0]  o_hgt_r;
  logic              o_last_r;

  always_comb begin
    prod     = NW'(cnt_r) * NW'(h1);
    ge       = (n_r >= d_r);
    st_nxt   = st_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    load     = 1'b0;
    case (st_r)
      SC_IDLE: begin
        if (feed.start) begin
          st_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        n_nxt    = (prod << 1) + NW'(mx_r);
        d_nxt    = NW'(mx_r) << HGT_W;
        step_nxt = '0;
        st_nxt   = SC_DIV;
      end
      SC_DIV: begin
        // One quotient bit per cycle, most significant first.
        n_nxt    = ge ? n_r - d_r : n_r;
        d_nxt    = d_r >> 1;
        q_nxt    = {q_r[HGT_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(HGT_W - 1)) begin
          st_nxt = SC_DONE;
        end
      end
      SC_DONE: begin
        if (!o_vld_r || out.ready) begin
          load   = 1'b1;
          st_nxt = SC_IDLE;
        end
      end
      default: st_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= SC_IDLE;
      o_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (load) begin
        o_vld_r <= 1'b1;
      end else if (out.ready) begin
        o_vld_r <= 1'b0;
      end
    end
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    if ((st_r == SC_IDLE) && feed.start) begin
      cnt_r  <= count;
      mx_r   <= max_count;
      idx_r  <= feed.idx;
      last_r <= feed.last;
      zero_r <= (max_count == '0);
    end
    if (load) begin
      o_idx_r  <= idx_r;
      o_hgt_r  <= zero_r ? '0 : q_r;
      o_last_r <= last_r;
    end
  end

  assign idle           = (st_r == SC_IDLE);
  assign out.valid      = o_vld_r;
  assign out.bin_index  = o_idx_r;
  assign out.bin_height = o_hgt_r;
  assign out.last_bin   = o_last_r;

endmodule

### sv/rgb555_adjusted_gray_histogram.sv
// Gray-level histogram of RGB555 pixels with optional brightness and contrast
// mapping. Within a frame one pixel request is taken every clock; each pixel
// is mapped, averaged into one of 32 bins and counted by a read-modify-write
// of the bin store, with forwarding between back-to-back hits on one bin.
// The request marked last_pixel closes the frame: input stays stalled while
// the pixel pipeline drains and the 32 bins are scaled and emitted in order.
// Each bin is scaled by the serial 16-step divider that forms the rounded
// height. The next pixel can be taken once the final bin enters the scaler,
// before that bin is emitted; a stalled output holds the sweep and the input
// with it. Emitted bins are cleared as they are read. The bin store comes out
// of reset empty through per-bin valid flags, so no clearing pass is needed.
// Configuration is to be written between frames; the block itself does not
// enforce this.
module rgb555_adjusted_gray_histogram import rgh_pkg::*; #(
  parameter longint unsigned MAX_PIXELS = RGH_MAX_PIXELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  rgh_pix_if.sink              in_pix,
  rgh_bin_if.source            out_bin
);

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  logic             adj_en_r;
  logic [8:0]       bright_r, contrast_r;
  logic [HGT_W-1:0] height_r;
  logic [HGT_W-1:0] h1;

  logic             take;
  logic             last_pend_r;
  logic             counting;
  logic             sc_idle;
  rgh_pix_t         pix;
  rgh_feed_t        feed;
  logic [CNT_W-1:0] count, max_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_en_r   <= 1'b0;
      bright_r   <= '0;
      contrast_r <= '0;
      height_r   <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ADJ_EN:   adj_en_r   <= cfg_wdata[0];
        CFG_BRIGHT:   bright_r   <= cfg_wdata[8:0];
        CFG_CONTRAST: contrast_r <= cfg_wdata[8:0];
        CFG_HEIGHT:   height_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A height of zero behaves as a height of one.
  assign h1 = (height_r == '0) ? '0 : height_r - HGT_W'(1);

  // Once the last pixel is in, hold off requests until the bin sweep is over.
  assign in_pix.ready = counting && !last_pend_r;
  assign take         = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pend_r <= 1'b0;
    end else if (take && in_pix.last_pixel) begin
      last_pend_r <= 1'b1;
    end else if (!counting) begin
      last_pend_r <= 1'b0;
    end
  end

  rgh_gray u_gray (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .pixel      (in_pix.pixel),
    .last_pixel (in_pix.last_pixel),
    .adj_en     (adj_en_r),
    .bright     (bright_r),
    .contrast   (contrast_r),
    .pix        (pix)
  );

  rgh_hist #(
    .MAX_PIXELS (MAX_PIXELS),
    .CNT_W      (CNT_W)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (pix),
    .sc_idle   (sc_idle),
    .feed      (feed),
    .count     (count),
    .max_count (max_count),
    .counting  (counting)
  );

  rgh_scale #(
    .CNT_W (CNT_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .feed      (feed),
    .count     (count),
    .max_count (max_count),
    .h1        (h1),
    .idle      (sc_idle),
    .out       (out_bin)
  );

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_pix.last_pixel) |=> !in_pix.ready)
    else $error("pixel request taken after the last pixel of a frame");

  a_last_bin_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bin.valid && out_bin.last_bin) |-> (out_bin.bin_index == BIN_W'(NUM_BINS - 1)))
    else $error("final bin flag on a bin other than the top one");

  a_feed_idle: assert property (@(posedge clk) disable iff (!rst_n)
    feed.start |-> (sc_idle && !counting))
    else $error("bin handed to the scaler outside the sweep or while it is busy");

endmodule
